// ----- sv/shell_sort_halving_gaps_unit_assert.svh -----
`ifndef SHELL_SORT_HALVING_GAPS_UNIT_ASSERT_SVH
`define SHELL_SORT_HALVING_GAPS_UNIT_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define SSHG_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated off during reset.
`define SSHG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sshg_pkg.sv -----
package sshg_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_UNLOAD
    } sshg_state_t;

endpackage

// ----- sv/sshg_cell.sv -----
// One slot of the insertion chain: keeps the smaller value, passes the larger on.
module sshg_cell #(
    parameter int DATA_WIDTH = sshg_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic                         carry_in_valid,
    input  logic signed [DATA_WIDTH-1:0] carry_in_data,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    output logic                         held_valid,
    output logic signed [DATA_WIDTH-1:0] held_data,
    output logic                         carry_out_valid,
    output logic signed [DATA_WIDTH-1:0] carry_out_data
);
    import sshg_pkg::*;

    logic                         held_valid_reg, held_valid_next;
    logic signed [DATA_WIDTH-1:0] held_data_reg, held_data_next;
    logic                         carry_valid_reg, carry_valid_next;
    logic signed [DATA_WIDTH-1:0] carry_data_reg, carry_data_next;

    always_comb
    begin
        held_valid_next  = held_valid_reg;
        held_data_next   = held_data_reg;
        carry_valid_next = 1'b0;
        carry_data_next  = carry_data_reg;
        if (shift)
        begin
            held_valid_next = right_valid;
            held_data_next  = right_data;
        end
        else if (carry_in_valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_data_next  = carry_in_data;
            end
            else if (carry_in_data < held_data_reg)
            begin
                held_data_next   = carry_in_data;
                carry_valid_next = 1'b1;
                carry_data_next  = held_data_reg;
            end
            else
            begin
                carry_valid_next = 1'b1;
                carry_data_next  = carry_in_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            carry_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            carry_valid_reg <= carry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_data_reg  <= held_data_next;
        carry_data_reg <= carry_data_next;
    end

    assign held_valid      = held_valid_reg;
    assign held_data       = held_data_reg;
    assign carry_out_valid = carry_valid_reg;
    assign carry_out_data  = carry_data_reg;

endmodule

// ----- sv/shell_sort_halving_gaps_unit.sv -----
// Sorter for sets of signed values, ascending order.
//
// Input channel (in_valid / in_stall, value, is_last): one value per item,
// one item per cycle while loading. is_last closes the set. Values beyond
// DEPTH are taken and dropped; every result of that set then shows overflowed.
// Output channel (out_valid / out_stall, sorted_value, is_final, overflowed):
// the set comes back smallest first, is_final on its last item.
//
// Each loaded value enters a chain of DEPTH cells; every cell keeps the smaller
// of what it holds and what arrives, and hands the larger to its right
// neighbor in the next cycle. After the closing item the chain settles while a
// counter loaded with the number of values held counts down to zero, then it
// drains from cell 0, shifting left once per taken result. A set is loaded,
// settled and unloaded in turn. in_stall is high from the closing item until
// the final result is taken. A stall on the output holds the current result
// and the chain in place. Reset empties the chain and returns to loading; no
// clearing pass is needed.
module shell_sort_halving_gaps_unit #(
    parameter int DEPTH      = sshg_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = sshg_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         is_final,
    output logic                         overflowed
);
    import sshg_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    sshg_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] settle_reg, settle_next;
    logic          drop_reg, drop_next;

    logic in_accept, out_accept, store_ok, shift;

    // chain wiring; slot DEPTH is the empty right edge
    logic                         held_v [DEPTH+1];
    logic signed [DATA_WIDTH-1:0] held_d [DEPTH+1];
    logic                         carry_v [DEPTH];
    logic signed [DATA_WIDTH-1:0] carry_d [DEPTH];

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign store_ok   = count_reg < CW'(DEPTH);

    // cell 0 takes the new value directly
    assign carry_v[0]    = in_accept && store_ok;
    assign carry_d[0]    = value;
    assign held_v[DEPTH] = 1'b0;
    assign held_d[DEPTH] = '0;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k < DEPTH - 1)
            begin : g_mid
                sshg_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                    .clk             (clk),
                    .rst_n           (rst_n),
                    .shift           (shift),
                    .carry_in_valid  (carry_v[k]),
                    .carry_in_data   (carry_d[k]),
                    .right_valid     (held_v[k+1]),
                    .right_data      (held_d[k+1]),
                    .held_valid      (held_v[k]),
                    .held_data       (held_d[k]),
                    .carry_out_valid (carry_v[k+1]),
                    .carry_out_data  (carry_d[k+1])
                );
            end
            else
            begin : g_end
                // never spills: at most DEPTH values are held
                sshg_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                    .clk             (clk),
                    .rst_n           (rst_n),
                    .shift           (shift),
                    .carry_in_valid  (carry_v[k]),
                    .carry_in_data   (carry_d[k]),
                    .right_valid     (held_v[k+1]),
                    .right_data      (held_d[k+1]),
                    .held_valid      (held_v[k]),
                    .held_data       (held_d[k]),
                    .carry_out_valid (),
                    .carry_out_data  ()
                );
            end
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_accept && is_last)
                    state_next = ST_SETTLE;
            ST_SETTLE:
                if (settle_reg == '0)
                    state_next = ST_UNLOAD;
            ST_UNLOAD:
                if (out_accept && count_reg == CW'(1))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:   in_stall  = 1'b0;
            ST_SETTLE: in_stall  = 1'b1;
            ST_UNLOAD: out_valid = 1'b1;
            default:   in_stall  = 1'b1;
        endcase
    end

    assign shift        = out_accept;
    assign sorted_value = held_d[0];
    assign is_final     = count_reg == CW'(1);
    assign overflowed   = drop_reg;

    // counters and drop flag
    always_comb
    begin
        count_next  = count_reg;
        settle_next = settle_reg;
        drop_next   = drop_reg;
        if (in_accept)
        begin
            if (store_ok)
                count_next = count_reg + CW'(1);
            else
                drop_next = 1'b1;
            if (is_last)
                settle_next = store_ok ? count_reg + CW'(1) : count_reg;
        end
        if (state_reg == ST_SETTLE && settle_reg != '0)
            settle_next = settle_reg - CW'(1);
        if (out_accept)
        begin
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
                drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            settle_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            settle_reg <= settle_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

// ----- sv/sshg_checker.sv -----
`include "shell_sort_halving_gaps_unit_assert.svh"

module sshg_checker #(
    parameter int DATA_WIDTH = sshg_pkg::DATA_WIDTH_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [DATA_WIDTH-1:0] sorted_value,
    input logic                         is_final,
    input logic                         overflowed
);
    import sshg_pkg::*;

    logic mid_take, final_take, in_take;

    assign mid_take   = out_valid && !out_stall && !is_final;
    assign final_take = out_valid && !out_stall && is_final;
    assign in_take    = in_valid && !in_stall;

    // results come out in ascending signed order
    `SSHG_ASSERT_NEXT(a_ascending, clk, rst_n, mid_take,
        out_valid && (sorted_value >= $past(sorted_value)))

    // overflow flag is the same across one set
    `SSHG_ASSERT_NEXT(a_flag_steady, clk, rst_n, mid_take, overflowed == $past(overflowed))

    // after the final result the block goes back to loading
    `SSHG_ASSERT_NEXT(a_back_to_load, clk, rst_n, final_take, !out_valid && !in_stall)

    // a stalled result holds
    `SSHG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(sorted_value) && $stable(is_final))

    // an item taken while loading never shows a result in the same cycle
    `SSHG_ASSERT_SAME(a_load_quiet, clk, rst_n, in_take, !out_valid)

endmodule

bind shell_sort_halving_gaps_unit sshg_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sshg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .is_final     (is_final),
    .overflowed   (overflowed)
);
